### rtl/tlge_pkg.sv
// Shared constants, operation codes and bit-count helper for the toroidal life grid engine.
package tlge_pkg;

  // storage word and configuration port geometry
  localparam int WORD_BITS = 64;
  localparam int CFG_W     = 9;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // result field widths
  localparam int LIVE_W = 17;
  localparam int GEN_W  = 32;
  localparam int CNT_W  = 16;

  // eight neighbor planes are summed for every row
  localparam int PLANES = 8;

  localparam logic [CFG_W-1:0] GRID_RESET_SIZE = 9'd64;

  // register index taken from paddr[2]
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  // count set bits of one storage word with a folded adder tree
  function automatic logic [6:0] popcount64(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    logic [WORD_BITS-1:0] c;
    logic [WORD_BITS-1:0] d;
    logic [WORD_BITS-1:0] e;
    logic [WORD_BITS-1:0] f;
    a = v - ((v >> 1) & 64'h5555_5555_5555_5555);
    b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
    c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    d = c + (c >> 8);
    e = d + (d >> 16);
    f = e + (e >> 32);
    return f[6:0];
  endfunction

endpackage

### rtl/toroidal_life_grid_engine.sv
// Top level of the toroidal life grid engine: config registers, sequencer, grid memory.
//
// Usage:
//   Requests arrive on the in_ channel (valid/ready) and carry one of four
//   operations: write a cell, read a cell, advance gen_count generations of
//   the B3/S23 rule on a wrapping grid, or clear. Every request returns one
//   result on the out_ channel: the cell read, the live population of the
//   grid in use and the generation number.
//   grid_width and grid_height are written over the APB-style port at byte
//   addresses 0 and 4 while the block is idle; pready is always high.
// Sequence:
//   every request ends with a population sweep over the rows in use; a
//   read first fetches its row, a write first reads and modifies its row
//   or zero-fills each row newly brought into use, and for each row a
//   generation makes 3 row fetches and adds 8 neighbor planes through one
//   shared shift/add unit, then writes back. Advancing stops early once a
//   generation changes nothing. One request is in flight at a time.
// Reset: config returns to 64 by 64, the grid reads as all dead (a row fill
//   count masks unwritten rows), and the block is ready at once.
// Stall: a finished result waits in the output register while the next
//   request is taken; the following result waits until the slot frees.
module toroidal_life_grid_engine #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tlge_pkg::PADDR_W-1:0]       paddr,
  input  logic [tlge_pkg::PDATA_W-1:0]       pwdata,
  output logic [tlge_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready,
  // request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_operation,
  input  logic [7:0]                         in_col,
  input  logic [7:0]                         in_row,
  input  logic                               in_live_value,
  input  logic [tlge_pkg::CNT_W-1:0]         in_gen_count,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_cell_value,
  output logic [tlge_pkg::LIVE_W-1:0]        out_live_total,
  output logic [tlge_pkg::GEN_W-1:0]         out_gen_number
);

  localparam int WB        = tlge_pkg::WORD_BITS;
  localparam int ROW_WORDS = (MAX_COLS + WB - 1) / WB;
  localparam int ROW_BITS  = ROW_WORDS * WB;
  localparam int CW        = $clog2(ROW_BITS);
  localparam int CWW       = $clog2(MAX_COLS + 1);
  localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int HW        = $clog2(MAX_ROWS + 1);
  localparam int AW        = RW + 1;
  localparam int CIW       = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
  localparam int STEP_W    = $clog2(tlge_pkg::PLANES);
  localparam int LIVE_W    = tlge_pkg::LIVE_W;
  localparam int GEN_W     = tlge_pkg::GEN_W;
  localparam int CNT_W     = tlge_pkg::CNT_W;
  localparam int CFG_W     = tlge_pkg::CFG_W;

  typedef enum logic [14:0] {
    ST_IDLE   = 15'b000000000000001,
    ST_W_FILL = 15'b000000000000010,
    ST_W_RD   = 15'b000000000000100,
    ST_W_MOD  = 15'b000000000001000,
    ST_R_RD   = 15'b000000000010000,
    ST_R_GET  = 15'b000000000100000,
    ST_G_RD0  = 15'b000000001000000,
    ST_G_RD1  = 15'b000000010000000,
    ST_G_RD2  = 15'b000000100000000,
    ST_G_RD3  = 15'b000001000000000,
    ST_G_ADD  = 15'b000010000000000,
    ST_G_WB   = 15'b000100000000000,
    ST_P_RD   = 15'b001000000000000,
    ST_P_CNT  = 15'b010000000000000,
    ST_DONE   = 15'b100000000000000
  } state_t;

  typedef enum logic [1:0] {
    PK_WEST   = 2'd0,
    PK_CENTER = 2'd1,
    PK_EAST   = 2'd2
  } plane_kind_t;

  // configuration registers
  logic [CFG_W-1:0] grid_width_r;
  logic [CFG_W-1:0] grid_height_r;
  logic             cfg_we;

  // sequencer state
  state_t              state_r, state_nxt;
  logic [CW-1:0]       col_r, col_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic                val_r, val_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [GEN_W-1:0]    gen_r, gen_nxt;
  logic [HW-1:0]       hi_r, hi_nxt;
  logic                cur_buf_r, cur_buf_nxt;
  logic [RW-1:0]       y_r, y_nxt;
  logic [RW-1:0]       fill_r, fill_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [CIW-1:0]      ci_r, ci_nxt;
  logic                changed_r, changed_nxt;
  logic [LIVE_W-1:0]   acc_r, acc_nxt;
  logic                cell_r, cell_nxt;
  logic [ROW_BITS-1:0] up_r, up_nxt;
  logic [ROW_BITS-1:0] mid_r, mid_nxt;
  logic [ROW_BITS-1:0] dn_r, dn_nxt;
  logic [ROW_BITS-1:0] s0_r, s0_nxt;
  logic [ROW_BITS-1:0] s1_r, s1_nxt;
  logic [ROW_BITS-1:0] s2_r, s2_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_cell_r, out_cell_nxt;
  logic [LIVE_W-1:0] out_live_r, out_live_nxt;
  logic [GEN_W-1:0]  out_gen_r, out_gen_nxt;

  // grid memory: two buffers of MAX_ROWS rows, buffer select on the top address bit
  logic [ROW_BITS-1:0] grid_mem [2**AW];
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ROW_BITS-1:0] mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic                rd_live_nxt;
  logic [ROW_BITS-1:0] rd_q_r;
  logic                rd_live_r;
  logic [ROW_BITS-1:0] row_data;

  // derived geometry
  logic [CWW-1:0]      w_eff;
  logic [HW-1:0]       h_eff;
  logic [ROW_BITS-1:0] col_mask;
  logic [CW-1:0]       wrap_idx;
  logic                y_last;
  logic [RW-1:0]       y_up;
  logic [RW-1:0]       y_dn;
  logic                in_range;
  tlge_pkg::op_t       req_op;

  // shared shift and plane-add unit
  plane_kind_t         kind;
  logic [ROW_BITS-1:0] src_row;
  logic [ROW_BITS-1:0] in_m;
  logic [ROW_BITS-1:0] plane;
  logic [ROW_BITS-1:0] carry0;
  logic [ROW_BITS-1:0] carry1;
  logic [ROW_BITS-1:0] add_s0;
  logic [ROW_BITS-1:0] add_s1;
  logic [ROW_BITS-1:0] add_s2;
  logic [ROW_BITS-1:0] next_row;
  logic                changed_now;
  logic [WB-1:0]       pop_word;
  logic                pop_start;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= tlge_pkg::GRID_RESET_SIZE;
      grid_height_r <= tlge_pkg::GRID_RESET_SIZE;
    end else if (cfg_we) begin
      if (paddr[2] == tlge_pkg::REG_GRID_WIDTH) begin
        grid_width_r <= pwdata[CFG_W-1:0];
      end else begin
        grid_height_r <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == tlge_pkg::REG_GRID_HEIGHT) ?
                  tlge_pkg::PDATA_W'(grid_height_r) : tlge_pkg::PDATA_W'(grid_width_r);

  // clamp sizes into 1..MAX
  always_comb begin
    if (grid_width_r == '0) begin
      w_eff = CWW'(1);
    end else if (32'(grid_width_r) > 32'(MAX_COLS)) begin
      w_eff = CWW'(MAX_COLS);
    end else begin
      w_eff = CWW'(grid_width_r);
    end
    if (grid_height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(grid_height_r) > 32'(MAX_ROWS)) begin
      h_eff = HW'(MAX_ROWS);
    end else begin
      h_eff = HW'(grid_height_r);
    end
  end

  // columns in use
  always_comb begin
    for (int i = 0; i < ROW_BITS; i++) begin
      col_mask[i] = (32'(i) < 32'(w_eff));
    end
  end

  assign wrap_idx = CW'(w_eff - CWW'(1));
  assign y_last   = ((32'(y_r) + 32'd1) == 32'(h_eff));
  assign y_up     = (y_r == '0) ? RW'(h_eff - HW'(1)) : y_r - RW'(1);
  assign y_dn     = y_last ? '0 : y_r + RW'(1);
  assign req_op   = tlge_pkg::op_t'(in_operation);
  assign in_range = (32'(in_col) < 32'(w_eff)) && (32'(in_row) < 32'(h_eff));

  // rows at or above the fill count read as dead
  assign row_data = rd_live_r ? rd_q_r : '0;

  // grid memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q_r    <= grid_mem[mem_raddr];
      rd_live_r <= rd_live_nxt;
    end
  end

  // pick the neighbor plane for this step: three above, two beside, three below
  always_comb begin
    case (step_r) inside
      [3'd0:3'd2]: src_row = up_r;
      [3'd3:3'd4]: src_row = mid_r;
      default:     src_row = dn_r;
    endcase
    case (step_r) inside
      3'd0, 3'd3, 3'd5: kind = PK_WEST;
      3'd1, 3'd6:       kind = PK_CENTER;
      default:          kind = PK_EAST;
    endcase
    in_m = src_row & col_mask;
    case (kind)
      PK_WEST: begin
        plane    = (in_m << 1) & col_mask;
        plane[0] = in_m[wrap_idx];
      end
      PK_EAST: begin
        plane           = in_m >> 1;
        plane[wrap_idx] = in_m[0];
      end
      default: begin
        plane = in_m;
      end
    endcase
    // add the plane into the per-cell 3-bit count
    carry0 = s0_r & plane;
    add_s0 = s0_r ^ plane;
    carry1 = s1_r & carry0;
    add_s1 = s1_r ^ carry0;
    add_s2 = s2_r ^ carry1;
  end

  // birth on three, survive on two or three
  assign next_row    = s1_r & ~s2_r & (s0_r | mid_r) & col_mask;
  assign changed_now = changed_r | (next_row != mid_r);
  assign pop_word    = row_data[int'(ci_r) * WB +: WB] & col_mask[int'(ci_r) * WB +: WB];

  assign in_ready = (state_r == ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    val_nxt     = val_r;
    rem_nxt     = rem_r;
    gen_nxt     = gen_r;
    hi_nxt      = hi_r;
    cur_buf_nxt = cur_buf_r;
    y_nxt       = y_r;
    fill_nxt    = fill_r;
    step_nxt    = step_r;
    ci_nxt      = ci_r;
    changed_nxt = changed_r;
    acc_nxt     = acc_r;
    cell_nxt    = cell_r;
    up_nxt      = up_r;
    mid_nxt     = mid_r;
    dn_nxt      = dn_r;
    s0_nxt      = s0_r;
    s1_nxt      = s1_r;
    s2_nxt      = s2_r;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    rd_live_nxt = 1'b0;
    pop_start   = 1'b0;

    out_valid_nxt = out_valid_r & ~out_ready;
    out_cell_nxt  = out_cell_r;
    out_live_nxt  = out_live_r;
    out_gen_nxt   = out_gen_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          col_nxt  = CW'(in_col);
          row_nxt  = RW'(in_row);
          val_nxt  = in_live_value;
          cell_nxt = 1'b0;
          case (req_op)
            tlge_pkg::OP_WRITE: begin
              if (!in_range) begin
                pop_start = 1'b1;
              end else if (32'(in_row) < 32'(hi_r)) begin
                state_nxt = ST_W_RD;
              end else begin
                // bring rows up to the target into use, zeroed
                fill_nxt  = RW'(hi_r);
                state_nxt = ST_W_FILL;
              end
            end
            tlge_pkg::OP_READ: begin
              if (in_range && (32'(in_row) < 32'(hi_r))) begin
                state_nxt = ST_R_RD;
              end else begin
                pop_start = 1'b1;
              end
            end
            tlge_pkg::OP_ADVANCE: begin
              gen_nxt = gen_r + GEN_W'(in_gen_count);
              if (in_gen_count == '0) begin
                pop_start = 1'b1;
              end else begin
                rem_nxt     = in_gen_count;
                y_nxt       = '0;
                // stale rows beyond the height die in the first generation
                changed_nxt = (32'(hi_r) > 32'(h_eff));
                state_nxt   = ST_G_RD0;
              end
            end
            tlge_pkg::OP_CLEAR: begin
              hi_nxt    = '0;
              gen_nxt   = '0;
              pop_start = 1'b1;
            end
            default: begin
              pop_start = 1'b1;
            end
          endcase
        end
      end

      ST_W_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = {cur_buf_r, fill_r};
        if (fill_r == row_r) begin
          mem_wdata = val_r ? (ROW_BITS'(1) << col_r) : '0;
          hi_nxt    = HW'(row_r) + HW'(1);
          pop_start = 1'b1;
        end else begin
          fill_nxt = fill_r + RW'(1);
        end
      end

      ST_W_RD: begin
        mem_re      = 1'b1;
        mem_raddr   = {cur_buf_r, row_r};
        rd_live_nxt = 1'b1;
        state_nxt   = ST_W_MOD;
      end

      ST_W_MOD: begin
        mem_we           = 1'b1;
        mem_waddr        = {cur_buf_r, row_r};
        mem_wdata        = row_data;
        mem_wdata[col_r] = val_r;
        pop_start        = 1'b1;
      end

      ST_R_RD: begin
        mem_re      = 1'b1;
        mem_raddr   = {cur_buf_r, row_r};
        rd_live_nxt = 1'b1;
        state_nxt   = ST_R_GET;
      end

      ST_R_GET: begin
        cell_nxt  = row_data[col_r];
        pop_start = 1'b1;
      end

      // fetch the row above, the row itself and the row below
      ST_G_RD0: begin
        mem_re      = 1'b1;
        mem_raddr   = {cur_buf_r, y_up};
        rd_live_nxt = (32'(y_up) < 32'(hi_r));
        state_nxt   = ST_G_RD1;
      end

      ST_G_RD1: begin
        mem_re      = 1'b1;
        mem_raddr   = {cur_buf_r, y_r};
        rd_live_nxt = (32'(y_r) < 32'(hi_r));
        up_nxt      = row_data;
        state_nxt   = ST_G_RD2;
      end

      ST_G_RD2: begin
        mem_re      = 1'b1;
        mem_raddr   = {cur_buf_r, y_dn};
        rd_live_nxt = (32'(y_dn) < 32'(hi_r));
        mid_nxt     = row_data;
        state_nxt   = ST_G_RD3;
      end

      ST_G_RD3: begin
        dn_nxt    = row_data;
        s0_nxt    = '0;
        s1_nxt    = '0;
        s2_nxt    = '0;
        step_nxt  = '0;
        state_nxt = ST_G_ADD;
      end

      // one neighbor plane per cycle through the shared unit
      ST_G_ADD: begin
        s0_nxt = add_s0;
        s1_nxt = add_s1;
        s2_nxt = add_s2;
        if (step_r == STEP_W'(tlge_pkg::PLANES - 1)) begin
          state_nxt = ST_G_WB;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end

      // write the new row into the other buffer
      ST_G_WB: begin
        mem_we    = 1'b1;
        mem_waddr = {~cur_buf_r, y_r};
        mem_wdata = next_row;
        if (y_last) begin
          cur_buf_nxt = ~cur_buf_r;
          hi_nxt      = h_eff;
          rem_nxt     = rem_r - CNT_W'(1);
          if ((rem_r == CNT_W'(1)) || !changed_now) begin
            pop_start = 1'b1;
          end else begin
            y_nxt       = '0;
            changed_nxt = 1'b0;
            state_nxt   = ST_G_RD0;
          end
        end else begin
          changed_nxt = changed_now;
          y_nxt       = y_dn;
          state_nxt   = ST_G_RD0;
        end
      end

      // population sweep over the rows in use
      ST_P_RD: begin
        mem_re      = 1'b1;
        mem_raddr   = {cur_buf_r, y_r};
        rd_live_nxt = (32'(y_r) < 32'(hi_r));
        ci_nxt      = '0;
        state_nxt   = ST_P_CNT;
      end

      ST_P_CNT: begin
        acc_nxt = acc_r + LIVE_W'(tlge_pkg::popcount64(pop_word));
        if (ci_r == CIW'(ROW_WORDS - 1)) begin
          if (y_last) begin
            state_nxt = ST_DONE;
          end else begin
            y_nxt     = y_dn;
            state_nxt = ST_P_RD;
          end
        end else begin
          ci_nxt = ci_r + CIW'(1);
        end
      end

      // hand the result over once the output slot is free
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = cell_r;
          out_live_nxt  = acc_r;
          out_gen_nxt   = gen_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (pop_start) begin
      y_nxt     = '0;
      ci_nxt    = '0;
      acc_nxt   = '0;
      state_nxt = ST_P_RD;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      gen_r       <= '0;
      hi_r        <= '0;
      cur_buf_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      gen_r       <= gen_nxt;
      hi_r        <= hi_nxt;
      cur_buf_r   <= cur_buf_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    val_r      <= val_nxt;
    rem_r      <= rem_nxt;
    y_r        <= y_nxt;
    fill_r     <= fill_nxt;
    step_r     <= step_nxt;
    ci_r       <= ci_nxt;
    changed_r  <= changed_nxt;
    acc_r      <= acc_nxt;
    cell_r     <= cell_nxt;
    up_r       <= up_nxt;
    mid_r      <= mid_nxt;
    dn_r       <= dn_nxt;
    s0_r       <= s0_nxt;
    s1_r       <= s1_nxt;
    s2_r       <= s2_nxt;
    out_cell_r <= out_cell_nxt;
    out_live_r <= out_live_nxt;
    out_gen_r  <= out_gen_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_cell_r;
  assign out_live_total = out_live_r;
  assign out_gen_number = out_gen_r;

  // one request at a time: ready drops right after a request is taken
  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in flight");

  // a result appears only when the sequencer finishes
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the finish state");

  // a generation never overwrites the buffer it is reading
  a_pingpong: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_G_WB) |-> (mem_we && (mem_waddr[AW-1] != cur_buf_r)))
    else $error("generation write-back hit the current buffer");

  // clear empties the grid and restarts the generation count
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (req_op == tlge_pkg::OP_CLEAR)) |=>
      ((gen_r == '0) && (hi_r == '0)))
    else $error("clear left rows or generations behind");

endmodule

### tb/sv/grid_reply_checker.sv
// Reply checker for the toroidal life grid engine: mirrors the grid and compares every reply.
`timescale 1ns / 1ps

module grid_reply_checker #(
  parameter int COLS = 256,
  parameter int ROWS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tlge_pkg::PADDR_W-1:0] paddr,
  input  logic [tlge_pkg::PDATA_W-1:0] pwdata,
  input  logic                         pready,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [1:0]                   in_operation,
  input  logic [7:0]                   in_col,
  input  logic [7:0]                   in_row,
  input  logic                         in_live_value,
  input  logic [tlge_pkg::CNT_W-1:0]   in_gen_count,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         out_cell_value,
  input  logic [tlge_pkg::LIVE_W-1:0]  out_live_total,
  input  logic [tlge_pkg::GEN_W-1:0]   out_gen_number,
  output int                           mismatches,
  output int                           outstanding
);
  import tlge_pkg::*;

  typedef struct packed {
    logic              cell_bit;
    logic [LIVE_W-1:0] live;
    logic [GEN_W-1:0]  gen;
  } grid_reply_t;

  // mirrored engine state
  logic [COLS-1:0]  grid [ROWS];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [GEN_W-1:0] gen_total;
  grid_reply_t      reply_fifo [$];
  grid_reply_t      want;

  // zero maps to one, anything past the store maps to the store size
  function automatic int clamp_size(logic [CFG_W-1:0] v, int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return int'(v);
  endfunction

  // one B3/S23 pass over the wrapped region; return 1 if any stored cell changed
  function automatic bit evolve_grid(int w, int h);
    logic [COLS-1:0] nxt [ROWS];
    int xm;
    int xp;
    int ym;
    int yp;
    int nb;
    bit changed;
    changed = 1'b0;
    for (int y = 0; y < ROWS; y++) nxt[y] = '0;
    for (int y = 0; y < h; y++) begin
      ym = (y + h - 1) % h;
      yp = (y + 1) % h;
      for (int x = 0; x < w; x++) begin
        // duplicates from tiny wraps count once per appearance
        xm = (x + w - 1) % w;
        xp = (x + 1) % w;
        nb = 0;
        nb = nb + grid[ym][xm] + grid[ym][x] + grid[ym][xp];
        nb = nb + grid[y][xm] + grid[y][xp];
        nb = nb + grid[yp][xm] + grid[yp][x] + grid[yp][xp];
        nxt[y][x] = (nb == 3) || (nb == 2 && grid[y][x]);
      end
    end
    // cells outside the region die, so they count as a change too
    for (int y = 0; y < ROWS; y++) begin
      if (nxt[y] != grid[y]) changed = 1'b1;
    end
    if (changed) begin
      for (int y = 0; y < ROWS; y++) grid[y] = nxt[y];
    end
    return changed;
  endfunction

  function automatic int count_live(int w, int h);
    int n;
    n = 0;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) n = n + grid[y][x];
    end
    return n;
  endfunction

  // apply one request to the mirror and build its reply
  function automatic grid_reply_t apply_request(op_t op, logic [7:0] col, logic [7:0] row,
                                                logic live_bit, logic [CNT_W-1:0] count);
    grid_reply_t r;
    int w;
    int h;
    w = clamp_size(width_reg, COLS);
    h = clamp_size(height_reg, ROWS);
    r = '0;
    case (op)
      OP_WRITE: begin
        if (col < w && row < h) grid[row][col] = live_bit;
      end
      OP_READ: begin
        if (col < w && row < h) r.cell_bit = grid[row][col];
      end
      OP_ADVANCE: begin
        // stop once a pass changes nothing, but count every generation asked
        for (int k = 0; k < count; k++) begin
          if (!evolve_grid(w, h)) break;
        end
        gen_total = gen_total + count;
      end
      default: begin
        for (int y = 0; y < ROWS; y++) grid[y] = '0;
        gen_total = '0;
      end
    endcase
    r.live = count_live(w, h);
    r.gen  = gen_total;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int y = 0; y < ROWS; y++) grid[y] = '0;
      width_reg  = GRID_RESET_SIZE;
      height_reg = GRID_RESET_SIZE;
      gen_total  = '0;
      reply_fifo.delete();
      mismatches = 0;
    end else begin
      // take register writes at the access phase
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_GRID_WIDTH) width_reg = pwdata[CFG_W-1:0];
        else height_reg = pwdata[CFG_W-1:0];
      end
      // match an accepted reply against the oldest prediction
      if (out_valid && out_ready) begin
        if (reply_fifo.size() == 0) begin
          $error("reply with no request outstanding: cell %0d live %0d gen %0d",
                 out_cell_value, out_live_total, out_gen_number);
          mismatches++;
        end else begin
          want = reply_fifo.pop_front();
          if (out_cell_value !== want.cell_bit) begin
            $error("out_cell_value: expected %0d, got %0d", want.cell_bit, out_cell_value);
            mismatches++;
          end
          if (out_live_total !== want.live) begin
            $error("out_live_total: expected %0d, got %0d", want.live, out_live_total);
            mismatches++;
          end
          if (out_gen_number !== want.gen) begin
            $error("out_gen_number: expected %0d, got %0d", want.gen, out_gen_number);
            mismatches++;
          end
        end
      end
      // predict the reply of an accepted request
      if (in_valid && in_ready) begin
        reply_fifo.push_back(apply_request(op_t'(in_operation), in_col, in_row,
                                           in_live_value, in_gen_count));
      end
    end
    outstanding = reply_fifo.size();
  end

endmodule

### tb/sv/testbench.sv
// Bench top for the toroidal life grid engine: clock, reset, request and register traffic, verdict.
`timescale 1ns / 1ps

module testbench;
  import tlge_pkg::*;

  localparam int COLS        = 256;
  localparam int ROWS        = 256;
  localparam int STALL_LIMIT = 200000;
  localparam int HOLD_CYCLES = 2500;
  localparam int TAIL_CYCLES = 2000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_operation;
  logic [7:0]         in_col;
  logic [7:0]         in_row;
  logic               in_live_value;
  logic [CNT_W-1:0]   in_gen_count;
  logic               out_valid;
  logic               out_ready;
  logic               out_cell_value;
  logic [LIVE_W-1:0]  out_live_total;
  logic [GEN_W-1:0]   out_gen_number;

  int mismatches;
  int outstanding;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_len;
  int quiet_cycles   = 0;
  // effective grid size, used to aim requests at the region
  int grid_w = 64;
  int grid_h = 64;

  always #6 clk = ~clk;

  toroidal_life_grid_engine #(
    .MAX_COLS(COLS),
    .MAX_ROWS(ROWS)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_col(in_col), .in_row(in_row), .in_live_value(in_live_value),
    .in_gen_count(in_gen_count),
    .out_valid(out_valid), .out_ready(out_ready), .out_cell_value(out_cell_value),
    .out_live_total(out_live_total), .out_gen_number(out_gen_number)
  );

  grid_reply_checker #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) reply_check (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_col(in_col), .in_row(in_row), .in_live_value(in_live_value),
    .in_gen_count(in_gen_count),
    .out_valid(out_valid), .out_ready(out_ready), .out_cell_value(out_cell_value),
    .out_live_total(out_live_total), .out_gen_number(out_gen_number),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // reply side: random stalls, or a long hold when one is requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_len     = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // offer one request and hold it until the engine takes it
  task automatic send_request(op_t op, logic [7:0] col, logic [7:0] row, logic live_bit,
                              logic [CNT_W-1:0] count);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_col        <= col;
    in_row        <= row;
    in_live_value <= live_bit;
    in_gen_count  <= count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid and wait for every outstanding reply
  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_register(logic reg_sel, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // resize only with the engine idle
  task automatic resize_grid(int wv, int hv);
    drain_replies();
    write_register(REG_GRID_WIDTH, wv);
    write_register(REG_GRID_HEIGHT, hv);
    grid_w = (wv == 0) ? 1 : ((wv > COLS) ? COLS : wv);
    grid_h = (hv == 0) ? 1 : ((hv > ROWS) ? ROWS : hv);
  endtask

  task automatic set_idling(int mode);
    send_idle_pct  = (mode == 1) ? 45 : ((mode == 3) ? 21 : 0);
    recv_stall_pct = (mode == 2) ? 45 : ((mode == 3) ? 21 : 0);
  endtask

  task automatic random_sequence();
    int kind;
    int x0;
    int y0;
    int gens;
    kind = $urandom_range(9, 0);
    x0   = $urandom_range(grid_w - 1, 0);
    y0   = $urandom_range(grid_h - 1, 0);
    if (kind < 6) begin
      // seed a small cluster, step it, probe around it
      repeat ($urandom_range(6, 3)) begin
        send_request(OP_WRITE, (x0 + $urandom_range(2, 0)) % grid_w,
                     (y0 + $urandom_range(2, 0)) % grid_h, $urandom_range(7, 0) != 0, $urandom);
      end
      gens = $urandom_range((grid_h > 64) ? 2 : 6, 1);
      send_request(OP_ADVANCE, $urandom, $urandom, $urandom, gens);
      repeat ($urandom_range(2, 1)) begin
        send_request(OP_READ, (x0 + $urandom_range(3, 0)) % grid_w,
                     (y0 + $urandom_range(3, 0)) % grid_h, $urandom, $urandom);
      end
    end else if (kind < 8) begin
      // clear, plant a still block, then a long advance that settles at once
      send_request(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
      if (grid_w >= 4 && grid_h >= 4) begin
        send_request(OP_WRITE, x0, y0, 1'b1, $urandom);
        send_request(OP_WRITE, (x0 + 1) % grid_w, y0, 1'b1, $urandom);
        send_request(OP_WRITE, x0, (y0 + 1) % grid_h, 1'b1, $urandom);
        send_request(OP_WRITE, (x0 + 1) % grid_w, (y0 + 1) % grid_h, 1'b1, $urandom);
      end
      send_request(OP_ADVANCE, $urandom, $urandom, $urandom, $urandom_range(65535, 0));
      send_request(OP_READ, x0, y0, $urandom, $urandom);
    end else begin
      // stray requests, often outside the region
      repeat ($urandom_range(3, 1)) begin
        send_request(op_t'($urandom_range(3, 0)), $urandom_range(255, 0),
                     $urandom_range(255, 0), $urandom, $urandom_range(3, 0));
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    in_operation  = OP_WRITE;
    in_col        = '0;
    in_row        = '0;
    in_live_value = 1'b0;
    in_gen_count  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners, out-of-region access, a still block across both wraps
    send_request(OP_READ, 0, 0, 1'b0, 0);
    send_request(OP_WRITE, 63, 63, 1'b1, 0);
    send_request(OP_WRITE, 0, 63, 1'b1, 0);
    send_request(OP_WRITE, 63, 0, 1'b1, 0);
    send_request(OP_WRITE, 0, 0, 1'b1, 0);
    send_request(OP_WRITE, 255, 255, 1'b1, 16'hFFFF);
    send_request(OP_WRITE, 64, 5, 1'b1, 0);
    send_request(OP_READ, 255, 255, 1'b1, 0);
    send_request(OP_ADVANCE, 0, 0, 1'b0, 16'hFFFF);
    send_request(OP_READ, 0, 63, 1'b0, 0);
    // blinker straddling the column wrap
    send_request(OP_WRITE, 63, 30, 1'b1, 0);
    send_request(OP_WRITE, 0, 30, 1'b1, 0);
    send_request(OP_WRITE, 1, 30, 1'b1, 0);
    send_request(OP_ADVANCE, 0, 0, 1'b0, 1);
    send_request(OP_READ, 0, 29, 1'b0, 0);
    send_request(OP_ADVANCE, 0, 0, 1'b0, 0);
    send_request(OP_WRITE, 0, 29, 1'b0, 0);
    send_request(OP_ADVANCE, 0, 0, 1'b0, 3);
    send_request(OP_WRITE, 10, 10, 1'b0, 0);
    send_request(OP_CLEAR, 255, 255, 1'b1, 16'hFFFF);
    send_request(OP_ADVANCE, 0, 0, 1'b0, 16'hFFFF);
    send_request(OP_READ, 63, 63, 1'b0, 0);

    // hold replies off long enough to back the engine up
    drain_replies();
    hold_request = HOLD_CYCLES;
    repeat (6) begin
      send_request($urandom_range(1, 0) ? OP_WRITE : OP_READ, $urandom_range(63, 0),
                   $urandom_range(63, 0), $urandom, $urandom);
    end
    drain_replies();

    // tiny and oversized regions
    set_idling(1);
    resize_grid(0, 1);
    repeat (2) random_sequence();
    set_idling(2);
    resize_grid(2, 0);
    repeat (2) random_sequence();
    set_idling(3);
    resize_grid(2, 2);
    random_sequence();
    set_idling(0);
    resize_grid(511, 3);
    repeat (2) random_sequence();
    set_idling(1);
    resize_grid(3, 300);
    random_sequence();
    set_idling(2);
    resize_grid(256, 256);
    random_sequence();

    // random sizes, leftover cells kept across each resize
    for (int p = 0; p < 4; p++) begin
      set_idling(p);
      if ($urandom_range(3, 0) == 0) resize_grid($urandom_range(511, 0), $urandom_range(3, 0));
      else resize_grid($urandom_range(96, 4), $urandom_range(32, 4));
      repeat (3) random_sequence();
    end

    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
rtl/tlge_pkg.sv
rtl/toroidal_life_grid_engine.sv
tb/sv/grid_reply_checker.sv
tb/sv/testbench.sv
